>>> sv/bmhq_pkg.sv
// ----------------------------------------------------------------------------
// bmhq_pkg: shared types and constants for the binary max-heap queue
// Widths, operation and status codes, controller states and the result record.
// ----------------------------------------------------------------------------
package bmhq_pkg;

  localparam int CAPACITY = 64;
  localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int KEY_W    = 32;
  localparam int SLOT_W   = 6;
  localparam int OP_W     = 2;
  localparam int STS_W    = 3;
  localparam int COUNT_W  = 7;

  // stream widths: data padded to whole bytes
  localparam int IN_DATA_W  = ((KEY_W + SLOT_W + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((2 * KEY_W + COUNT_W + 7) / 8) * 8;

  typedef logic signed [KEY_W-1:0] key_t;
  typedef logic [ADDR_W-1:0]       addr_t;
  typedef logic [CNT_W-1:0]        cnt_t;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT   = 2'd0,
    OP_EXTRACT  = 2'd1,
    OP_INCREASE = 2'd2,
    OP_NOP      = 2'd3
  } op_t;

  typedef enum logic [STS_W-1:0] {
    STS_OK         = 3'd0,
    STS_EMPTY      = 3'd1,
    STS_FULL       = 3'd2,
    STS_BAD_INDEX  = 3'd3,
    STS_NOT_LARGER = 3'd4
  } sts_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_UP_CHECK,
    S_UP_WAIT,
    S_INC_WAIT,
    S_DN_LOAD,
    S_DN_CHECK,
    S_DN_LEFT,
    S_DN_RIGHT,
    S_DONE
  } state_t;

  typedef struct packed {
    sts_t               status;
    key_t               removed;
    key_t               top;
    logic [COUNT_W-1:0] count;
  } result_t;

  function automatic logic key_less(input key_t a, input key_t b);
    return a < b;
  endfunction

endpackage

>>> sv/bmhq_ram.sv
// ----------------------------------------------------------------------------
// bmhq_ram: generic single-write, single-read synchronous RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module bmhq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> sv/bmhq_ctrl.sv
// ----------------------------------------------------------------------------
// bmhq_ctrl: heap sequencer
// Runs one operation at a time against the heap RAM: sift up carries the new
// key in a register and moves parents down; sift down moves the larger child up.
// ----------------------------------------------------------------------------
module bmhq_ctrl
  import bmhq_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  // request side
  input  logic               req_valid,
  output logic               req_ready,
  input  op_t                req_op,
  input  key_t               req_key,
  input  logic [SLOT_W-1:0]  req_slot,
  // result side
  output logic               res_valid,
  input  logic               res_take,
  output result_t            res,
  // heap RAM
  output logic               mem_we,
  output addr_t              mem_waddr,
  output key_t               mem_wdata,
  output addr_t              mem_raddr,
  input  key_t               mem_rdata
);

  localparam int CMP_W  = ADDR_W + 2;
  localparam int SCMP_W = (SLOT_W > CNT_W) ? SLOT_W : CNT_W;

  state_t state_r, state_nxt;
  cnt_t   count_r, count_nxt;
  key_t   top_r,   top_nxt;
  addr_t  pos_r,   pos_nxt;
  key_t   k_r,     k_nxt;
  key_t   cval_r,  cval_nxt;
  addr_t  cidx_r,  cidx_nxt;
  sts_t   status_r, status_nxt;
  key_t   removed_r, removed_nxt;

  addr_t            parent;
  logic [CMP_W-1:0] child_l;
  logic [CMP_W-1:0] count_x;
  addr_t            lidx;
  logic             has_left;
  logic             has_right;
  key_t             best_val;
  addr_t            best_idx;

  assign parent    = addr_t'((pos_r - 1'b1) >> 1);
  assign child_l   = CMP_W'({pos_r, 1'b1});
  assign count_x   = CMP_W'(count_r);
  assign lidx      = child_l[ADDR_W-1:0];
  assign has_left  = child_l < count_x;
  assign has_right = (child_l + 1'b1) < count_x;

  always_comb begin
    state_nxt   = state_r;
    count_nxt   = count_r;
    pos_nxt     = pos_r;
    k_nxt       = k_r;
    cval_nxt    = cval_r;
    cidx_nxt    = cidx_r;
    status_nxt  = status_r;
    removed_nxt = removed_r;
    mem_we      = 1'b0;
    mem_waddr   = pos_r;
    mem_wdata   = k_r;
    mem_raddr   = '0;
    req_ready   = 1'b0;
    res_valid   = 1'b0;
    best_val    = mem_rdata;
    best_idx    = lidx;

    case (state_r)
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          status_nxt  = STS_OK;
          removed_nxt = '0;
          case (req_op)
            OP_INSERT: begin
              if (count_r >= cnt_t'(CAPACITY)) begin
                status_nxt = STS_FULL;
                state_nxt  = S_DONE;
              end else begin
                k_nxt     = req_key;
                pos_nxt   = addr_t'(count_r);
                count_nxt = count_r + 1'b1;
                state_nxt = S_UP_CHECK;
              end
            end
            OP_EXTRACT: begin
              if (count_r == '0) begin
                status_nxt = STS_EMPTY;
                state_nxt  = S_DONE;
              end else begin
                removed_nxt = top_r;
                count_nxt   = count_r - 1'b1;
                mem_raddr   = addr_t'(count_r - 1'b1);
                state_nxt   = S_DN_LOAD;
              end
            end
            OP_INCREASE: begin
              if (SCMP_W'(req_slot) >= SCMP_W'(count_r)) begin
                status_nxt = STS_BAD_INDEX;
                state_nxt  = S_DONE;
              end else begin
                k_nxt     = req_key;
                pos_nxt   = addr_t'(req_slot);
                mem_raddr = addr_t'(req_slot);
                state_nxt = S_INC_WAIT;
              end
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end

      S_INC_WAIT: begin
        if (key_less(k_r, mem_rdata)) begin
          status_nxt = STS_NOT_LARGER;
          state_nxt  = S_DONE;
        end else begin
          state_nxt = S_UP_CHECK;
        end
      end

      S_UP_CHECK: begin
        if (pos_r == '0) begin
          mem_we    = 1'b1;
          state_nxt = S_DONE;
        end else begin
          mem_raddr = parent;
          state_nxt = S_UP_WAIT;
        end
      end

      S_UP_WAIT: begin
        mem_we = 1'b1;
        if (key_less(mem_rdata, k_r)) begin
          // parent moves down into the hole
          mem_wdata = mem_rdata;
          pos_nxt   = parent;
          state_nxt = S_UP_CHECK;
        end else begin
          state_nxt = S_DONE;
        end
      end

      S_DN_LOAD: begin
        k_nxt   = mem_rdata;
        pos_nxt = '0;
        if (count_r == '0) begin
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_DN_CHECK;
        end
      end

      S_DN_CHECK: begin
        if (!has_left) begin
          mem_we    = 1'b1;
          state_nxt = S_DONE;
        end else begin
          mem_raddr = lidx;
          state_nxt = S_DN_LEFT;
        end
      end

      S_DN_LEFT: begin
        if (has_right) begin
          cval_nxt  = mem_rdata;
          cidx_nxt  = lidx;
          mem_raddr = lidx + 1'b1;
          state_nxt = S_DN_RIGHT;
        end else begin
          mem_we = 1'b1;
          if (key_less(k_r, mem_rdata)) begin
            mem_wdata = mem_rdata;
            pos_nxt   = lidx;
            state_nxt = S_DN_CHECK;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end

      S_DN_RIGHT: begin
        // left wins ties
        if (key_less(cval_r, mem_rdata)) begin
          best_val = mem_rdata;
          best_idx = cidx_r + 1'b1;
        end else begin
          best_val = cval_r;
          best_idx = cidx_r;
        end
        mem_we = 1'b1;
        if (key_less(k_r, best_val)) begin
          mem_wdata = best_val;
          pos_nxt   = best_idx;
          state_nxt = S_DN_CHECK;
        end else begin
          state_nxt = S_DONE;
        end
      end

      S_DONE: begin
        res_valid = 1'b1;
        if (res_take) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // root shadow
    top_nxt = (mem_we && (mem_waddr == '0)) ? mem_wdata : top_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    top_r     <= top_nxt;
    pos_r     <= pos_nxt;
    k_r       <= k_nxt;
    cval_r    <= cval_nxt;
    cidx_r    <= cidx_nxt;
    status_r  <= status_nxt;
    removed_r <= removed_nxt;
  end

  assign res.status  = status_r;
  assign res.removed = removed_r;
  assign res.top     = (count_r != '0) ? top_r : '0;
  assign res.count   = COUNT_W'(count_r);

endmodule

>>> sv/binary_max_heap_queue.sv
// ----------------------------------------------------------------------------
// binary_max_heap_queue: binary max-heap priority queue of signed 32-bit keys
// Insert, extract-max and increase-key on a 64-entry heap held in one RAM.
// ----------------------------------------------------------------------------
// Usage:
//  - Input stream (in_*): one request per handshake. in_tuser carries the
//    operation (insert, extract max, increase key, no-op); in_tdata the key
//    and, for increase-key, the heap slot.
//  - Output stream (out_*): exactly one result per request, in order: status
//    in out_tuser, removed key, current maximum and entry count in out_tdata.
//  - Requests run one at a time. A status-only result (full, empty, bad
//    index, no-op) needs no RAM access; insert sifts up, reading one parent
//    per level; increase-key first reads its slot, then sifts up as insert
//    does; extract reads the last entry, then sifts down. The sequencer
//    passes through its idle state before the next request is taken. The
//    single read port of the heap RAM sets the pace: each level waits on
//    one or two reads.
//  - A finished result sits in the output register; the next request is
//    taken meanwhile, and its result waits in the sequencer until the
//    output register frees. A stalled receiver thus holds off at most one
//    further request.
//  - Reset empties the heap (count to zero) at once; RAM contents are not
//    cleared, since only entries below the count are ever read.
// ----------------------------------------------------------------------------
module binary_max_heap_queue
  import bmhq_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // request stream
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // key[31:0], slot_index[37:32], zero pad
  input  logic [OP_W-1:0]       in_tuser,   // operation[1:0]
  // result stream
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // removed_value[31:0], top_value[63:32],
                                            // entry_count[70:64], zero pad
  output logic [STS_W-1:0]      out_tuser   // status[2:0]
);

  logic    res_valid;
  logic    res_take;
  result_t res;

  logic    mem_we;
  addr_t   mem_waddr;
  key_t    mem_wdata;
  addr_t   mem_raddr;
  key_t    mem_rdata;

  logic    out_valid_r, out_valid_nxt;
  result_t out_res_r,   out_res_nxt;

  // heap storage
  bmhq_ram #(
    .WIDTH (KEY_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // operation sequencer
  bmhq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (in_tvalid),
    .req_ready (in_tready),
    .req_op    (op_t'(in_tuser)),
    .req_key   (key_t'(in_tdata[KEY_W-1:0])),
    .req_slot  (in_tdata[KEY_W+SLOT_W-1:KEY_W]),
    .res_valid (res_valid),
    .res_take  (res_take),
    .res       (res),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  // output register: loads when empty or being drained this cycle
  assign res_take = res_valid && (!out_valid_r || out_tready);

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_res_nxt   = out_res_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (res_take) begin
      out_valid_nxt = 1'b1;
      out_res_nxt   = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r <= out_res_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_res_r.status;
  assign out_tdata  = OUT_DATA_W'({out_res_r.count, out_res_r.top, out_res_r.removed});

endmodule

>>> bench/binary_max_heap_queue_tb.sv
// ----------------------------------------------------------------------------
// binary_max_heap_queue_tb: self-checking bench for the max-heap queue
// Sends insert, extract-max, increase-key and no-op requests through the
// input stream and keeps its own heap model in step with every accepted
// request. Each result is compared field by field against the model, in
// order. Both stream sides idle at random in two phases; a third has no idling.
// ----------------------------------------------------------------------------
module binary_max_heap_queue_tb
  import bmhq_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam key_t KEY_MAX = key_t'(32'h7fff_ffff);
  localparam key_t KEY_MIN = key_t'(32'h8000_0000);

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;   // key[31:0], slot_index[37:32], zero pad
  logic [OP_W-1:0]       in_tuser   = OP_NOP; // operation[1:0]
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;         // removed[31:0], top[63:32], count[70:64]
  logic [STS_W-1:0]      out_tuser;         // status[2:0]

  // heap model, updated as each request is accepted
  key_t    heap_model [CAPACITY];
  int      model_count = 0;
  result_t expected_results [$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int error_count   = 0;
  int requests_sent = 0;
  int results_seen  = 0;
  int status_tally [5] = '{default: 0};

  binary_max_heap_queue dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #1 clk = ~clk;

  // --------------------------------------------------------------------------
  // Heap model
  // --------------------------------------------------------------------------
  // parent of slot i is (i-1)/2
  function automatic void heap_sift_up(input int pos);
    int   parent;
    key_t tmp;
    while (pos > 0) begin
      parent = (pos - 1) / 2;
      if (!(heap_model[parent] < heap_model[pos])) break;
      tmp                = heap_model[parent];
      heap_model[parent] = heap_model[pos];
      heap_model[pos]    = tmp;
      pos                = parent;
    end
  endfunction

  // applies one request to the model and returns the result it must produce
  function automatic result_t heap_apply(input op_t op, input key_t key,
                                         input logic [SLOT_W-1:0] slot);
    result_t r;
    int      pos;
    int      child;
    key_t    tmp;
    r        = '0;
    r.status = STS_OK;
    case (op)
      OP_INSERT: begin
        if (model_count >= CAPACITY) begin
          r.status = STS_FULL;
        end else begin
          heap_model[model_count] = key;
          model_count++;
          heap_sift_up(model_count - 1);
        end
      end
      OP_EXTRACT: begin
        if (model_count == 0) begin
          r.status = STS_EMPTY;
        end else begin
          r.removed = heap_model[0];
          model_count--;
          heap_model[0] = heap_model[model_count];
          // sift down, promoting the larger child
          pos = 0;
          while (2 * pos + 1 < model_count) begin
            child = 2 * pos + 1;
            if (child + 1 < model_count && heap_model[child] < heap_model[child + 1])
              child++;
            if (!(heap_model[pos] < heap_model[child])) break;
            tmp               = heap_model[pos];
            heap_model[pos]   = heap_model[child];
            heap_model[child] = tmp;
            pos               = child;
          end
        end
      end
      OP_INCREASE: begin
        if (int'(slot) >= model_count) begin
          r.status = STS_BAD_INDEX;
        end else if (key < heap_model[slot]) begin
          r.status = STS_NOT_LARGER;
        end else begin
          heap_model[slot] = key;
          heap_sift_up(int'(slot));
        end
      end
      default: ;  // no-op leaves the heap alone
    endcase
    r.top   = (model_count > 0) ? heap_model[0] : key_t'(0);
    r.count = COUNT_W'(model_count);
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Request side
  // --------------------------------------------------------------------------
  // Holds tvalid high across back-to-back requests; drops it only for a gap.
  task automatic send_request(input op_t op, input key_t key,
                              input logic [SLOT_W-1:0] slot);
    int gap;
    gap = 0;
    while ($urandom_range(0, 99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {2'b00, slot, key};
    in_tuser  <= op;
    do @(posedge clk); while (!in_tready);
    expected_results.insert(expected_results.size(), heap_apply(op, key, slot));
    requests_sent++;
  endtask

  // full-range keys, small keys for duplicates, keys near both extremes
  function automatic key_t random_key();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 50) return key_t'($urandom);
    if (pick < 80) return key_t'(int'($urandom_range(0, 80)) - 40);
    if (pick < 90) return KEY_MAX - key_t'($urandom_range(0, 20));
    return KEY_MIN + key_t'($urandom_range(0, 20));
  endfunction

  // --------------------------------------------------------------------------
  // Result side
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  task automatic check_field(input string name, input longint expected_val,
                             input longint actual_val);
    if (expected_val != actual_val) begin
      $display("%0t ns: %s mismatch, expected %0d, actual %0d",
               $time, name, expected_val, actual_val);
      error_count++;
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      if (out_tuser < 5) status_tally[out_tuser]++;
      if (expected_results.size() == 0) begin
        $display("%0t ns: result with no request pending, status %0d, data %h",
                 $time, out_tuser, out_tdata);
        error_count++;
      end else begin
        want = expected_results.pop_front();
        check_field("status", want.status, out_tuser);
        check_field("removed_value", want.removed, key_t'(out_tdata[31:0]));
        check_field("top_value", want.top, key_t'(out_tdata[63:32]));
        check_field("entry_count", want.count, out_tdata[70:64]);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // extract, increase-key and no-op on an empty heap, including a top slot index
  task automatic test_empty_heap();
    send_request(OP_EXTRACT, key_t'(0), '0);
    send_request(OP_INCREASE, key_t'(5), '0);
    send_request(OP_INCREASE, KEY_MAX, SLOT_W'(CAPACITY - 1));
    send_request(OP_NOP, key_t'(-1), SLOT_W'(CAPACITY - 1));
  endtask

  // extreme keys, duplicates, increase ok / equal / lower / bad slot, drain
  task automatic test_key_extremes();
    int min_slot;
    send_request(OP_INSERT, key_t'(0), '0);
    send_request(OP_INSERT, KEY_MAX, '0);
    send_request(OP_INSERT, KEY_MIN, '0);
    send_request(OP_INSERT, key_t'(-1), '0);
    send_request(OP_INSERT, key_t'(7), '0);
    send_request(OP_INSERT, key_t'(7), '0);
    min_slot = 0;
    for (int i = 0; i < model_count; i++)
      if (heap_model[i] == KEY_MIN) min_slot = i;
    send_request(OP_INCREASE, key_t'(100), SLOT_W'(min_slot));  // sifts up
    send_request(OP_INCREASE, key_t'(0), '0);                   // below the root
    send_request(OP_INCREASE, KEY_MAX, '0);                     // equal key
    send_request(OP_INCREASE, key_t'(1), SLOT_W'(model_count)); // just past the end
    send_request(OP_NOP, KEY_MIN, '0);
    repeat (7) send_request(OP_EXTRACT, key_t'(0), '0);         // last one on empty
  endtask

  // ascending inserts sift to the root each time; then full, then drain
  task automatic test_full_heap();
    for (int i = 0; i < CAPACITY; i++)
      send_request(OP_INSERT, KEY_MIN + key_t'(i * 1000), SLOT_W'(i));
    send_request(OP_INSERT, KEY_MAX, '0);
    send_request(OP_INCREASE, KEY_MIN, SLOT_W'(CAPACITY - 1));
    send_request(OP_INCREASE, KEY_MAX, SLOT_W'(CAPACITY - 1));
    send_request(OP_NOP, key_t'(0), '0);
    repeat (CAPACITY + 1) send_request(OP_EXTRACT, random_key(), SLOT_W'($urandom));
  endtask

  // Mostly well-formed traffic; the insert share shifts every 40 requests so
  // the fill level swings between empty and full. A few requests are noise.
  task automatic test_random_traffic(input int n);
    int                  insert_pct;
    int                  pick;
    longint              raised;
    op_t                 op;
    key_t                key;
    logic [SLOT_W-1:0]   slot;
    insert_pct = 50;
    for (int i = 0; i < n; i++) begin
      if (i % 40 == 0) insert_pct = 20 + 30 * int'($urandom_range(0, 2));
      key  = random_key();
      slot = SLOT_W'($urandom_range(0, 63));
      if ($urandom_range(0, 99) < 5) begin
        op = ($urandom_range(0, 1) != 0) ? OP_NOP : OP_INCREASE;
      end else if ($urandom_range(0, 99) < insert_pct) begin
        op = OP_INSERT;
      end else if ($urandom_range(0, 99) < 65) begin
        op = OP_EXTRACT;
      end else begin
        op = OP_INCREASE;
        if (model_count > 0) begin
          slot = SLOT_W'($urandom_range(0, model_count - 1));
          pick = $urandom_range(0, 99);
          if (pick < 70) begin
            raised = longint'(heap_model[slot]) + longint'($urandom_range(0, 5000));
            if (raised > longint'(KEY_MAX)) raised = longint'(KEY_MAX);
            key = key_t'(raised);
          end else if (pick < 80) begin
            key = heap_model[slot];
          end
        end
      end
      send_request(op, key, slot);
    end
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct = 15;
    recv_idle_pct = 55;
    test_empty_heap();
    test_key_extremes();
    test_full_heap();
    test_random_traffic(220);

    send_idle_pct = 55;
    recv_idle_pct = 15;
    test_random_traffic(220);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_traffic(220);

    in_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("%0d requests sent, %0d results checked, %0d errors",
             requests_sent, results_seen, error_count);
    $display("statuses ok/empty/full/bad index/not larger: %0d/%0d/%0d/%0d/%0d",
             status_tally[0], status_tally[1], status_tally[2],
             status_tally[3], status_tally[4]);
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // watchdog: far beyond the slowest correct run
  initial begin
    #2_000_000;
    $display("timeout with %0d results outstanding", expected_results.size());
    $display("simulation failed");
    $finish;
  end

endmodule
